### hw/rtl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg: shared definitions for the Cartesian to polar converter
// Holds default widths, the arctangent step table, angle codes and the
// control bundle that travels with each item through the pipeline.
// ----------------------------------------------------------------------------
package ctp_pkg;

	// Width of the input and output fields on the ports.
	localparam int FIELD_WIDTH = 16;

	// Defaults for the top-level parameters.
	localparam int COORD_WIDTH_DEF    = 16;
	localparam int ROTATION_STEPS_DEF = 16;

	// Extra fraction bits carried by the rotation datapath.
	localparam int GUARD_BITS = 24;

	// Number of entries in the arctangent table.
	localparam int ATAN_ENTRIES = 32;

	// Angle accumulator starting value for the left half plane (pi).
	localparam logic [31:0] ACC_PI = 32'h8000_0000;

	// Rounding offset applied before the accumulator is cut to 16 bits.
	localparam logic [31:0] ACC_ROUND = 32'h0000_8000;

	// Angle codes for points on the axes, in units of pi/32768.
	localparam logic [FIELD_WIDTH-1:0] ANG_ZERO        = 16'h0000;
	localparam logic [FIELD_WIDTH-1:0] ANG_PI          = 16'h8000;
	localparam logic [FIELD_WIDTH-1:0] ANG_HALF_PI     = 16'h4000;
	localparam logic [FIELD_WIDTH-1:0] ANG_NEG_HALF_PI = 16'hC000;

	// Largest magnitude that fits the output field.
	localparam logic [FIELD_WIDTH-1:0] MAG_MAX = 16'hFFFF;

	// atan(2^-i) in units of pi/2^31, truncated.
	localparam logic [31:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	// Control bundle carried alongside the data of every stage.
	typedef struct packed {
		logic                   valid;
		logic                   spec;
		logic [FIELD_WIDTH-1:0] spec_ang;
	} ctl_t;

endpackage

### hw/rtl/ctp_prep.sv
// ----------------------------------------------------------------------------
// ctp_prep: front end of the converter
// Captures the coordinates, forms the squares, resolves points on the axes,
// folds the left half plane and sums the squares for the root lanes.
// ----------------------------------------------------------------------------
module ctp_prep #(
	parameter int COORD_WIDTH = ctp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [ctp_pkg::FIELD_WIDTH-1:0] x_coord,
	input  logic signed [ctp_pkg::FIELD_WIDTH-1:0] y_coord,
	output ctp_pkg::ctl_t                          ctl_out,
	output logic [2*COORD_WIDTH-1:0]               rem_out,
	output logic [2*COORD_WIDTH-1:0]               root_out,
	output logic signed [COORD_WIDTH+ctp_pkg::GUARD_BITS+2:0] cx_out,
	output logic signed [COORD_WIDTH+ctp_pkg::GUARD_BITS+2:0] cy_out,
	output logic [31:0]                            acc_out
);

	localparam int SQ_W = 2 * COORD_WIDTH;
	localparam int ROT_W = COORD_WIDTH + ctp_pkg::GUARD_BITS + 3;

	logic [COORD_WIDTH-1:0] x_low;
	logic [COORD_WIDTH-1:0] y_low;

	logic                          vld_s1;
	logic signed [COORD_WIDTH-1:0] xs_s1;
	logic signed [COORD_WIDTH-1:0] ys_s1;

	logic [COORD_WIDTH-1:0]  ax;
	logic [COORD_WIDTH-1:0]  ay;
	logic signed [ROT_W-1:0] xe;
	logic signed [ROT_W-1:0] ye;
	logic                    neg;
	ctp_pkg::ctl_t           ctl_next;

	ctp_pkg::ctl_t           ctl_s2;
	logic [SQ_W-1:0]         sqx_s2;
	logic [SQ_W-1:0]         sqy_s2;
	logic signed [ROT_W-1:0] cx_s2;
	logic signed [ROT_W-1:0] cy_s2;
	logic [31:0]             acc_s2;

	ctp_pkg::ctl_t           ctl_s3;
	logic [SQ_W-1:0]         sum_s3;
	logic signed [ROT_W-1:0] cx_s3;
	logic signed [ROT_W-1:0] cy_s3;
	logic [31:0]             acc_s3;

	// Take the low bits of each field; a wider coordinate sees the field zero-extended.
	if (COORD_WIDTH <= ctp_pkg::FIELD_WIDTH) begin : g_narrow
		assign x_low = x_coord[COORD_WIDTH-1:0];
		assign y_low = y_coord[COORD_WIDTH-1:0];
	end else begin : g_wide
		assign x_low = {{(COORD_WIDTH-ctp_pkg::FIELD_WIDTH){1'b0}}, x_coord};
		assign y_low = {{(COORD_WIDTH-ctp_pkg::FIELD_WIDTH){1'b0}}, y_coord};
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	// Stage 1 data: the coordinates as signed values.
	always_ff @(posedge clk) begin
		if (en) begin
			xs_s1 <= signed'(x_low);
			ys_s1 <= signed'(y_low);
		end
	end

	// Absolute values, axis detection and the left half plane fold.
	always_comb begin
		ax  = xs_s1[COORD_WIDTH-1] ? $unsigned(-xs_s1) : $unsigned(xs_s1);
		ay  = ys_s1[COORD_WIDTH-1] ? $unsigned(-ys_s1) : $unsigned(ys_s1);
		xe  = ROT_W'(xs_s1);
		ye  = ROT_W'(ys_s1);
		neg = xs_s1[COORD_WIDTH-1];

		ctl_next.valid = vld_s1;
		ctl_next.spec  = (xs_s1 == '0) || (ys_s1 == '0);
		if ((xs_s1 == '0) && (ys_s1 == '0)) begin
			ctl_next.spec_ang = ctp_pkg::ANG_ZERO;
		end else if (ys_s1 == '0) begin
			ctl_next.spec_ang = neg ? ctp_pkg::ANG_PI : ctp_pkg::ANG_ZERO;
		end else if (ys_s1[COORD_WIDTH-1]) begin
			ctl_next.spec_ang = ctp_pkg::ANG_NEG_HALF_PI;
		end else begin
			ctl_next.spec_ang = ctp_pkg::ANG_HALF_PI;
		end
	end

	// Stage 2 and stage 3 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_next;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 2 squares and rotation start; stage 3 sum of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= SQ_W'(ax) * SQ_W'(ax);
			sqy_s2 <= SQ_W'(ay) * SQ_W'(ay);
			cx_s2  <= (neg ? -xe : xe) <<< ctp_pkg::GUARD_BITS;
			cy_s2  <= (neg ? -ye : ye) <<< ctp_pkg::GUARD_BITS;
			acc_s2 <= neg ? ctp_pkg::ACC_PI : 32'h0000_0000;

			sum_s3 <= sqx_s2 + sqy_s2;
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
			acc_s3 <= acc_s2;
		end
	end

	assign ctl_out  = ctl_s3;
	assign rem_out  = sum_s3;
	assign root_out = '0;
	assign cx_out   = cx_s3;
	assign cy_out   = cy_s3;
	assign acc_out  = acc_s3;

endmodule

### hw/rtl/ctp_step.sv
// ----------------------------------------------------------------------------
// ctp_step: one stage of the converter pipeline
// Performs one digit of the integer square root and one vectoring rotation,
// each only while its step count has not been reached, and registers both.
// ----------------------------------------------------------------------------
module ctp_step #(
	parameter int COORD_WIDTH    = ctp_pkg::COORD_WIDTH_DEF,
	parameter int ROTATION_STEPS = ctp_pkg::ROTATION_STEPS_DEF,
	parameter int STEP           = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  ctp_pkg::ctl_t            ctl_in,
	input  logic [2*COORD_WIDTH-1:0] rem_in,
	input  logic [2*COORD_WIDTH-1:0] root_in,
	input  logic signed [COORD_WIDTH+ctp_pkg::GUARD_BITS+2:0] cx_in,
	input  logic signed [COORD_WIDTH+ctp_pkg::GUARD_BITS+2:0] cy_in,
	input  logic [31:0]              acc_in,
	output ctp_pkg::ctl_t            ctl_out,
	output logic [2*COORD_WIDTH-1:0] rem_out,
	output logic [2*COORD_WIDTH-1:0] root_out,
	output logic signed [COORD_WIDTH+ctp_pkg::GUARD_BITS+2:0] cx_out,
	output logic signed [COORD_WIDTH+ctp_pkg::GUARD_BITS+2:0] cy_out,
	output logic [31:0]              acc_out
);

	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int ROT_W = COORD_WIDTH + ctp_pkg::GUARD_BITS + 3;

	logic [SQ_W-1:0]         rem_next;
	logic [SQ_W-1:0]         root_next;
	logic signed [ROT_W-1:0] cx_next;
	logic signed [ROT_W-1:0] cy_next;
	logic [31:0]             acc_next;

	// This module is a single pipeline stage; its registers are its stage 1.
	ctp_pkg::ctl_t           ctl_s1;
	logic [SQ_W-1:0]         rem_s1;
	logic [SQ_W-1:0]         root_s1;
	logic signed [ROT_W-1:0] cx_s1;
	logic signed [ROT_W-1:0] cy_s1;
	logic [31:0]             acc_s1;

	// Square root digit: subtract the trial value when it fits.
	if (STEP < COORD_WIDTH) begin : g_root
		localparam int SHIFT = 2 * (COORD_WIDTH - 1 - STEP);
		localparam logic [SQ_W:0] SQ_BIT = (SQ_W + 1)'(1) << SHIFT;

		logic [SQ_W:0] trial;
		logic          fits;

		always_comb begin
			trial = {1'b0, root_in} + SQ_BIT;
			fits  = {1'b0, rem_in} >= trial;
			if (fits) begin
				rem_next  = rem_in - trial[SQ_W-1:0];
				root_next = (root_in >> 1) + SQ_BIT[SQ_W-1:0];
			end else begin
				rem_next  = rem_in;
				root_next = root_in >> 1;
			end
		end
	end else begin : g_root_pass
		assign rem_next  = rem_in;
		assign root_next = root_in;
	end

	// Vectoring rotation: drive y toward zero and track the angle.
	if (STEP < ROTATION_STEPS) begin : g_rot
		localparam logic [31:0] ATAN_STEP = ctp_pkg::ATAN_TABLE[STEP];

		logic signed [ROT_W-1:0] dx;
		logic signed [ROT_W-1:0] dy;

		always_comb begin
			dx = cy_in >>> STEP;
			dy = cx_in >>> STEP;
			if (!cy_in[ROT_W-1]) begin
				cx_next  = cx_in + dx;
				cy_next  = cy_in - dy;
				acc_next = acc_in + ATAN_STEP;
			end else begin
				cx_next  = cx_in - dx;
				cy_next  = cy_in + dy;
				acc_next = acc_in - ATAN_STEP;
			end
		end
	end else begin : g_rot_pass
		assign cx_next  = cx_in;
		assign cy_next  = cy_in;
		assign acc_next = acc_in;
	end

	// Stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_next;
			root_s1 <= root_next;
			cx_s1   <= cx_next;
			cy_s1   <= cy_next;
			acc_s1  <= acc_next;
		end
	end

	assign ctl_out  = ctl_s1;
	assign rem_out  = rem_s1;
	assign root_out = root_s1;
	assign cx_out   = cx_s1;
	assign cy_out   = cy_s1;
	assign acc_out  = acc_s1;

endmodule

### hw/rtl/ctp_out.sv
// ----------------------------------------------------------------------------
// ctp_out: result rounding and output buffering
// Rounds the root and the angle, applies the axis cases and saturation, and
// holds results in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module ctp_out #(
	parameter int COORD_WIDTH = ctp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ctp_pkg::ctl_t                        ctl_in,
	input  logic [2*COORD_WIDTH-1:0]             rem_in,
	input  logic [2*COORD_WIDTH-1:0]             root_in,
	input  logic [31:0]                          acc_in,
	output logic                                 en,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ctp_pkg::FIELD_WIDTH-1:0]        magnitude,
	output logic signed [ctp_pkg::FIELD_WIDTH-1:0] angle
);

	localparam int SQ_W = 2 * COORD_WIDTH;

	logic [SQ_W-1:0]                 root_rnd;
	logic [31:0]                     acc_rnd;
	logic [ctp_pkg::FIELD_WIDTH-1:0] mag_next;
	logic [ctp_pkg::FIELD_WIDTH-1:0] ang_next;
	logic                            out_free;

	logic                            out_valid_q;
	logic                            skid_valid_q;
	logic [ctp_pkg::FIELD_WIDTH-1:0] mag_q;
	logic [ctp_pkg::FIELD_WIDTH-1:0] ang_q;
	logic [ctp_pkg::FIELD_WIDTH-1:0] skid_mag_q;
	logic [ctp_pkg::FIELD_WIDTH-1:0] skid_ang_q;

	// Round the root to nearest, saturate, and round the angle half up.
	always_comb begin
		root_rnd = root_in + SQ_W'(rem_in > root_in);
		if (root_rnd > SQ_W'(ctp_pkg::MAG_MAX)) begin
			mag_next = ctp_pkg::MAG_MAX;
		end else begin
			mag_next = root_rnd[ctp_pkg::FIELD_WIDTH-1:0];
		end
		acc_rnd  = acc_in + ctp_pkg::ACC_ROUND;
		ang_next = ctl_in.spec ? ctl_in.spec_ang : acc_rnd[31:16];
	end

	// The pipeline advances while the skid register is empty.
	assign en       = !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	// Output and skid occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || ctl_in.valid;
			skid_valid_q <= 1'b0;
		end else if (en && ctl_in.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output and skid data: the skid drains first, otherwise the newest result.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				mag_q <= skid_mag_q;
				ang_q <= skid_ang_q;
			end else begin
				mag_q <= mag_next;
				ang_q <= ang_next;
			end
		end else if (en) begin
			skid_mag_q <= mag_next;
			skid_ang_q <= ang_next;
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = mag_q;
	assign angle     = signed'(ang_q);

endmodule

### hw/rtl/cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar: Cartesian to polar coordinate converter
// Takes one (x, y) pair per transfer and returns the rounded magnitude and
// the angle atan2(y, x) in units of pi/32768. One pair is accepted every
// clock cycle while in_stall is low. Each pair moves through the pipeline in
// order: three front stages capture, square and sum, then one stage per
// square root digit and per rotation runs both in parallel lanes, then the
// output register. The output register is backed by a skid register, so
// input transfers continue while a finished result waits; in_stall rises
// only once both are full.
// ----------------------------------------------------------------------------
module cartesian_to_polar #(
	parameter int COORD_WIDTH    = ctp_pkg::COORD_WIDTH_DEF,
	parameter int ROTATION_STEPS = ctp_pkg::ROTATION_STEPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [ctp_pkg::FIELD_WIDTH-1:0] x_coord,
	input  logic signed [ctp_pkg::FIELD_WIDTH-1:0] y_coord,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [ctp_pkg::FIELD_WIDTH-1:0]        magnitude,
	output logic signed [ctp_pkg::FIELD_WIDTH-1:0] angle
);

	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int ROT_W = COORD_WIDTH + ctp_pkg::GUARD_BITS + 3;
	localparam int NUM_STEPS = (COORD_WIDTH > ROTATION_STEPS) ? COORD_WIDTH : ROTATION_STEPS;

	logic en;

	ctp_pkg::ctl_t           ctl_w  [0:NUM_STEPS];
	logic [SQ_W-1:0]         rem_w  [0:NUM_STEPS];
	logic [SQ_W-1:0]         root_w [0:NUM_STEPS];
	logic signed [ROT_W-1:0] cx_w   [0:NUM_STEPS];
	logic signed [ROT_W-1:0] cy_w   [0:NUM_STEPS];
	logic [31:0]             acc_w  [0:NUM_STEPS];

	// Front end: capture, squares, axis cases, half plane fold.
	ctp_prep #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.ctl_out  (ctl_w[0]),
		.rem_out  (rem_w[0]),
		.root_out (root_w[0]),
		.cx_out   (cx_w[0]),
		.cy_out   (cy_w[0]),
		.acc_out  (acc_w[0])
	);

	// Root digit and rotation stages.
	for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
		ctp_step #(
			.COORD_WIDTH    (COORD_WIDTH),
			.ROTATION_STEPS (ROTATION_STEPS),
			.STEP           (k)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_in   (ctl_w[k]),
			.rem_in   (rem_w[k]),
			.root_in  (root_w[k]),
			.cx_in    (cx_w[k]),
			.cy_in    (cy_w[k]),
			.acc_in   (acc_w[k]),
			.ctl_out  (ctl_w[k+1]),
			.rem_out  (rem_w[k+1]),
			.root_out (root_w[k+1]),
			.cx_out   (cx_w[k+1]),
			.cy_out   (cy_w[k+1]),
			.acc_out  (acc_w[k+1])
		);
	end

	// Rounding, output register and skid register.
	ctp_out #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_w[NUM_STEPS]),
		.rem_in    (rem_w[NUM_STEPS]),
		.root_in   (root_w[NUM_STEPS]),
		.acc_in    (acc_w[NUM_STEPS]),
		.en        (en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.magnitude (magnitude),
		.angle     (angle)
	);

	assign in_stall = !en;

endmodule

### hw/rtl/ctp_checker.sv
// ----------------------------------------------------------------------------
// ctp_checker: port-level checks for the converter
// Watches the top-level ports for buffering and result consistency, and is
// attached to every instance of the top level.
// ----------------------------------------------------------------------------
module ctp_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic [ctp_pkg::FIELD_WIDTH-1:0]        magnitude,
	input logic signed [ctp_pkg::FIELD_WIDTH-1:0] angle
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// Input back-pressure only exists while a result sits at the output.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty output register");

	// Back-pressure starts only after the output was stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall rose without an output stall");

	// A zero magnitude can only come from the origin, whose angle is zero.
	a_origin_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (magnitude == '0) |-> (angle == '0))
		else $error("zero magnitude with a nonzero angle");

endmodule

bind cartesian_to_polar ctp_checker u_ctp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.magnitude (magnitude),
	.angle     (angle)
);
